// ===== sv/sld_pkg.sv =====
package sld_pkg;

    // default width of the discard and output counters
    localparam int unsigned COUNT_BITS_DEF = 16;

    // configuration and format constants
    localparam int unsigned LIMIT_W    = 16;
    localparam logic [15:0] LIMIT_RST  = 16'hFFFF;
    localparam logic [2:0]  HDR_LEN    = 3'd4;
    localparam logic [7:0]  COPY_BIT   = 8'h80;
    localparam logic [7:0]  RUN_MASK   = 8'h7F;

    // item commands
    localparam logic [2:0] CMD_START      = 3'd0;
    localparam logic [2:0] CMD_DELTA_BYTE = 3'd1;
    localparam logic [2:0] CMD_DELTA_END  = 3'd2;
    localparam logic [2:0] CMD_BASE_BYTE  = 3'd3;
    localparam logic [2:0] CMD_BASE_END   = 3'd4;

    // decoder phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CMD    = 3'd1,
        PH_COPY   = 3'd2,
        PH_LIT    = 3'd3,
        PH_TAIL   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // one input item
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
    } t_item;

    // one result item
    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [15:0] out_total;
        logic        done_res;
        logic        need_base;
        logic        protocol_error;
    } t_result;

endpackage

// ===== sv/sld_in_stage.sv =====
module sld_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sld_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output sld_pkg::t_item o_item
);
    import sld_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    // space when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // held item
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/sld_core.sv =====
module sld_core #(
    parameter int unsigned COUNT_BITS = sld_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_limit,
    input  logic             i_valid,
    input  sld_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output sld_pkg::t_result o_result
);
    import sld_pkg::*;

    localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // decoder state
    t_phase                r_phase, n_phase;
    logic [2:0]            r_hdr, n_hdr;
    logic [6:0]            r_run, n_run;
    logic [COUNT_BITS-1:0] r_drop, n_drop;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_bf, n_bf;

    // result register
    logic    r_out_valid;
    t_result r_res, n_res;

    logic       s_valid;
    logic       s_err;
    logic [2:0] cmd;
    logic [7:0] b;
    logic [2:0] hdr_dec;
    logic [6:0] run_dec;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] lim_ext;

    assign cmd = i_item.command;
    assign b   = i_item.data_byte;

    // item moves into the result register when that register is free or being emptied
    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    assign hdr_dec = (r_hdr != 3'd0) ? r_hdr - 3'd1 : r_hdr;
    assign run_dec = (r_run != 7'd0) ? r_run - 7'd1 : r_run;

    // per-item output byte and error flag
    always_comb begin
        s_valid = 1'b0;
        s_err   = 1'b0;
        unique case (cmd)
            CMD_START: begin
                s_err = 1'b0;
            end
            CMD_DELTA_BYTE, CMD_DELTA_END, CMD_BASE_BYTE, CMD_BASE_END: begin
                unique case (r_phase)
                    PH_HEADER, PH_CMD: begin
                        s_err = (cmd != CMD_DELTA_BYTE) && (cmd != CMD_DELTA_END);
                    end
                    PH_COPY, PH_TAIL: begin
                        s_err   = (cmd != CMD_BASE_BYTE) && (cmd != CMD_BASE_END);
                        s_valid = (cmd == CMD_BASE_BYTE) && (r_drop == '0);
                    end
                    PH_LIT: begin
                        s_err   = (cmd != CMD_DELTA_BYTE) && (cmd != CMD_DELTA_END);
                        s_valid = (cmd == CMD_DELTA_BYTE);
                    end
                    default: begin
                        s_err = 1'b0;
                    end
                endcase
            end
            default: begin
                s_err = 1'b1;
            end
        endcase
    end

    // next decoder state
    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_run   = r_run;
        n_drop  = r_drop;
        n_bf    = r_bf;
        if (cmd == CMD_START) begin
            n_phase = PH_HEADER;
            n_hdr   = HDR_LEN;
            n_run   = '0;
            n_drop  = '0;
            n_bf    = 1'b0;
        end else if (!s_err) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        n_hdr = hdr_dec;
                        if (hdr_dec == 3'd0) begin
                            n_phase = PH_CMD;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_CMD: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        n_run = b[6:0] & RUN_MASK[6:0];
                        if (n_run != 7'd0) begin
                            n_phase = ((b & COPY_BIT) != 8'd0) ? PH_COPY : PH_LIT;
                        end
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_COPY: begin
                    if (cmd == CMD_BASE_BYTE) begin
                        if (r_drop != '0) begin
                            n_drop = r_drop - CNT_ONE;
                        end else begin
                            n_run = run_dec;
                            if (run_dec == 7'd0) begin
                                n_phase = PH_CMD;
                            end
                        end
                    end else begin
                        n_bf = 1'b1;
                    end
                end
                PH_LIT: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        if (r_drop != CNT_MAX) begin
                            n_drop = r_drop + CNT_ONE;
                        end
                        n_run = run_dec;
                        if (run_dec == 7'd0) begin
                            n_phase = PH_CMD;
                        end
                    end else begin
                        n_run   = '0;
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (cmd == CMD_BASE_BYTE) begin
                        if (r_drop != '0) begin
                            n_drop = r_drop - CNT_ONE;
                        end
                    end else begin
                        n_bf    = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        // output counter, cleared by a start item
        if (cmd == CMD_START) begin
            n_count = '0;
        end else if (s_valid && (r_count != CNT_MAX)) begin
            n_count = r_count + CNT_ONE;
        end else begin
            n_count = r_count;
        end

        // base already ended: copy runs collapse and the tail is over
        if ((n_phase == PH_COPY) && n_bf) begin
            n_run   = '0;
            n_phase = PH_CMD;
        end
        if ((n_phase == PH_TAIL) && n_bf) begin
            n_phase = PH_DONE;
        end
        // output limit reached or too small to hold a header
        if ((n_phase != PH_DONE) &&
            ((i_limit < 16'(HDR_LEN)) || (CMP_W'(n_count) >= lim_ext))) begin
            n_phase = PH_DONE;
        end
    end

    assign cnt_ext = CMP_W'(n_count);
    assign lim_ext = CMP_W'(i_limit);

    // result fields
    always_comb begin
        n_res.out_valid      = s_valid;
        n_res.out_byte       = s_valid ? b : 8'd0;
        n_res.out_total      = cnt_ext[15:0];
        n_res.done_res       = (n_phase == PH_DONE);
        n_res.need_base      = (n_phase == PH_COPY) || (n_phase == PH_TAIL);
        n_res.protocol_error = s_err;
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr       <= HDR_LEN;
            r_run       <= '0;
            r_drop      <= '0;
            r_count     <= '0;
            r_bf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_run   <= n_run;
                r_drop  <= n_drop;
                r_count <= n_count;
                r_bf    <= n_bf;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== sv/skip_literal_delta_decoder.sv =====
// channel   dir  tdata                              tuser
// s_axis    in   [7:0] data_byte                    [2:0] command
// m_axis    out  [7:0] out_byte, [23:8] out_total   [0] out_valid, [1] done_res,
//                                                   [2] need_base, [3] protocol_error
// cfg       in   i_cfg_wr_data[15:0] output_limit, written while i_cfg_wr_en is high
//
// one item per cycle sustained while m_axis_tready is high; an accepted item goes
// through the input register and then the result register to m_axis; the decoder
// state is read and updated between the two and written with the result register
// synchronous active-low reset clears the stream state and sets the limit to 65535
// a stalled result holds in the result register while one more item waits in the
// input register
module skip_literal_delta_decoder #(
    parameter int unsigned COUNT_BITS = sld_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_total
    output logic [3:0]  m_axis_tuser,   // [0] out_valid, [1] done_res, [2] need_base,
                                        // [3] protocol_error
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import sld_pkg::*;

    logic [15:0] r_limit;
    t_item       in_item;
    t_item       held_item;
    logic        held_valid;
    logic        take;
    t_result     res;

    // output limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    assign in_item.command   = s_axis_tuser;
    assign in_item.data_byte = s_axis_tdata;

    // input register
    sld_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    // decoder step and result register
    sld_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_limit),
        .i_valid  (held_valid),
        .i_item   (held_item),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    // result packing
    assign m_axis_tdata = {res.out_total, res.out_byte};
    assign m_axis_tuser = {res.protocol_error, res.need_base, res.done_res, res.out_valid};

endmodule

// ===== sv/sld_checker.sv =====
module sld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [3:0]  i_m_tuser
);

    // a stalled result item holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // no byte is carried unless flagged
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[0] |-> i_m_tdata[7:0] == 8'd0)
        else $error("byte present without out_valid");

    // an ignored item produces no byte
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[3] |-> !i_m_tuser[0])
        else $error("protocol error with output byte");

    // a finished stream never asks for base
    a_done_no_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |-> !i_m_tuser[2])
        else $error("done and need_base together");

endmodule

bind skip_literal_delta_decoder sld_checker u_sld_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sld_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [2:0]  s_axis_tuser = 3'd0;    // [2:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] out_byte, [23:8] out_total
    logic [3:0]  m_axis_tuser;           // [0] out_valid, [1] done_res, [2] need_base,
                                         // [3] protocol_error
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'h0000;

    // own copy of the decoder state
    t_phase      dec_phase;
    logic [2:0]  hdr_left;
    logic [6:0]  run_cnt;
    logic [15:0] drop_cnt;
    logic [15:0] byte_cnt;
    logic        base_ended;
    logic [15:0] limit_reg;

    t_result     decoded_q[$];
    int unsigned err_cnt = 0;
    int unsigned tx_cnt = 0;
    int unsigned rx_cnt = 0;
    int unsigned byte_hits = 0;
    int unsigned limit_writes = 0;
    int unsigned cycle_cnt = 0;
    int unsigned rx_hold = 0;
    bit          quiet = 1'b0;
    bit          tx_on = 1'b0;

    skip_literal_delta_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_hold <= pick_gap();
        end
    end

    function automatic void clear_stream();
        dec_phase  = PH_HEADER;
        hdr_left   = HDR_LEN;
        run_cnt    = '0;
        drop_cnt   = '0;
        byte_cnt   = '0;
        base_ended = 1'b0;
    endfunction

    // one step of the rebuild: updates the state copy, returns the result item
    function automatic t_result decode_item(logic [2:0] cmd, logic [7:0] dbyte);
        t_result r;
        logic    hit;
        logic    bad;
        hit = 1'b0;
        bad = 1'b0;
        if (cmd > CMD_BASE_END) begin
            bad = 1'b1;
        end else if (cmd == CMD_START) begin
            clear_stream();
        end else begin
            case (dec_phase)
                PH_HEADER: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        if (hdr_left != 0)
                            hdr_left--;
                        if (hdr_left == 0)
                            dec_phase = PH_CMD;
                    end else if (cmd == CMD_DELTA_END) begin
                        dec_phase = PH_DONE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_CMD: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        // copy and literal runs share the low seven bits
                        run_cnt = 7'(dbyte & RUN_MASK);
                        if (run_cnt != 0)
                            dec_phase = ((dbyte & COPY_BIT) != 0) ? PH_COPY : PH_LIT;
                    end else if (cmd == CMD_DELTA_END) begin
                        dec_phase = PH_TAIL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_COPY: begin
                    if (cmd == CMD_BASE_BYTE) begin
                        if (drop_cnt != 0) begin
                            drop_cnt--;
                        end else begin
                            hit = 1'b1;
                            if (run_cnt != 0)
                                run_cnt--;
                            if (run_cnt == 0)
                                dec_phase = PH_CMD;
                        end
                    end else if (cmd == CMD_BASE_END) begin
                        base_ended = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_LIT: begin
                    if (cmd == CMD_DELTA_BYTE) begin
                        hit = 1'b1;
                        if (drop_cnt != COUNT_MAX)
                            drop_cnt++;
                        if (run_cnt != 0)
                            run_cnt--;
                        if (run_cnt == 0)
                            dec_phase = PH_CMD;
                    end else if (cmd == CMD_DELTA_END) begin
                        run_cnt = '0;
                        dec_phase = PH_TAIL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_TAIL: begin
                    if (cmd == CMD_BASE_BYTE) begin
                        if (drop_cnt != 0)
                            drop_cnt--;
                        else
                            hit = 1'b1;
                    end else if (cmd == CMD_BASE_END) begin
                        base_ended = 1'b1;
                        dec_phase = PH_DONE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                // finished: delta and base items are absorbed
                default: dec_phase = PH_DONE;
            endcase
        end

        if (hit && byte_cnt != COUNT_MAX)
            byte_cnt++;
        // a copy or tail cannot go on once the base is over
        if (dec_phase == PH_COPY && base_ended) begin
            run_cnt = '0;
            dec_phase = PH_CMD;
        end
        if (dec_phase == PH_TAIL && base_ended)
            dec_phase = PH_DONE;
        if (dec_phase != PH_DONE && (limit_reg < HDR_LEN || byte_cnt >= limit_reg))
            dec_phase = PH_DONE;

        r.out_valid      = hit;
        r.out_byte       = hit ? dbyte : 8'h00;
        r.out_total      = byte_cnt;
        r.done_res       = (dec_phase == PH_DONE);
        r.need_base      = (dec_phase == PH_COPY || dec_phase == PH_TAIL);
        r.protocol_error = bad;
        return r;
    endfunction

    // offer one item, hold it until accepted, then maybe idle
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] dbyte,
                             output t_result r);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= dbyte;
        tx_on = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = decode_item(cmd, dbyte);
        decoded_q.push_back(r);
        tx_cnt++;
        if (r.out_valid)
            byte_hits++;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            tx_on = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_all_results();
        if (tx_on) begin
            s_axis_tvalid <= 1'b0;
            tx_on = 1'b0;
        end
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [15:0] value);
        wait_all_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_reg = value;
        limit_writes++;
    endtask

    task automatic flag_field(string what, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        err_cnt++;
    endtask

    // compare each result item with the oldest outstanding one
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_valid      = m_axis_tuser[0];
            got.done_res       = m_axis_tuser[1];
            got.need_base      = m_axis_tuser[2];
            got.protocol_error = m_axis_tuser[3];
            got.out_byte       = m_axis_tdata[7:0];
            got.out_total      = m_axis_tdata[23:8];
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                rx_cnt++;
                if (got.out_valid !== want.out_valid)
                    flag_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
                if (got.out_byte !== want.out_byte)
                    flag_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
                if (got.out_total !== want.out_total)
                    flag_field("out_total", want.out_total, got.out_total);
                if (got.done_res !== want.done_res)
                    flag_field("done_res", 16'(want.done_res), 16'(got.done_res));
                if (got.need_base !== want.need_base)
                    flag_field("need_base", 16'(want.need_base), 16'(got.need_base));
                if (got.protocol_error !== want.protocol_error)
                    flag_field("protocol_error", 16'(want.protocol_error),
                               16'(got.protocol_error));
            end
        end
    end

    // short delta, unknown and misplaced items, zero runs, restart, misplaced base end
    task automatic test_stream_rules();
        t_result r;
        send_item(CMD_DELTA_END, 8'h00, r);
        send_item(3'd5, 8'hFF, r);
        send_item(3'd6, 8'h00, r);
        send_item(3'd7, 8'hFF, r);
        send_item(CMD_START, 8'h00, r);
        send_item(CMD_BASE_BYTE, 8'hFF, r);
        send_item(CMD_DELTA_BYTE, 8'h00, r);
        send_item(CMD_DELTA_BYTE, 8'hFF, r);
        send_item(CMD_START, 8'hFF, r);
        send_item(CMD_DELTA_BYTE, 8'h00, r);
        send_item(CMD_DELTA_BYTE, 8'hFF, r);
        send_item(CMD_DELTA_BYTE, 8'h12, r);
        send_item(CMD_DELTA_BYTE, 8'h34, r);
        send_item(CMD_DELTA_BYTE, COPY_BIT, r);
        send_item(CMD_DELTA_BYTE, 8'h00, r);
        send_item(CMD_DELTA_BYTE, 8'h03, r);
        send_item(CMD_DELTA_BYTE, 8'hFF, r);
        send_item(CMD_DELTA_BYTE, 8'h00, r);
        send_item(CMD_DELTA_BYTE, 8'hA5, r);
        send_item(CMD_DELTA_BYTE, 8'h81, r);
        send_item(CMD_DELTA_BYTE, 8'h5A, r);
        send_item(CMD_BASE_BYTE, 8'h11, r);
        send_item(CMD_BASE_END, 8'h00, r);
        send_item(CMD_DELTA_END, 8'h00, r);
        send_item(CMD_BASE_BYTE, 8'h77, r);
    endtask

    // limit below four, and a limit lowered to the running count
    task automatic test_output_limit();
        t_result r;
        set_limit(16'h0000);
        send_item(CMD_START, 8'h00, r);
        set_limit(16'd6);
        send_item(CMD_START, 8'h00, r);
        repeat (4) send_item(CMD_DELTA_BYTE, 8'($urandom), r);
        send_item(CMD_DELTA_BYTE, 8'h05, r);
        repeat (5) send_item(CMD_DELTA_BYTE, 8'($urandom), r);
        set_limit(16'd5);
        send_item(CMD_DELTA_BYTE, COPY_BIT, r);
    endtask

    // mostly well-formed streams with random content, some noise and broken streams
    task automatic run_random(int unsigned n_items, logic [15:0] lim, bit calm);
        t_result     r;
        logic [2:0]  cmd;
        logic [7:0]  dbyte;
        logic [6:0]  run;
        int unsigned pick;
        int unsigned counted;
        bit          was_done;
        set_limit(lim);
        quiet = calm;
        counted = 0;
        while (counted < n_items) begin
            pick  = $urandom_range(0, 99);
            dbyte = 8'($urandom);
            cmd   = CMD_DELTA_BYTE;
            run   = 7'($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0)
                run = '0;
            else if ($urandom_range(0, 19) == 0)
                run = 7'($urandom_range(20, 127));
            if (pick < 6) begin
                cmd = 3'($urandom_range(0, 7));
            end else if (pick < 8) begin
                cmd = CMD_START;
            end else begin
                case (dec_phase)
                    PH_HEADER: if (pick > 95) cmd = CMD_DELTA_END;
                    PH_CMD: begin
                        if (pick > 88)
                            cmd = CMD_DELTA_END;
                        else
                            dbyte = ($urandom_range(0, 1) ? COPY_BIT : 8'h00) | {1'b0, run};
                    end
                    PH_COPY: cmd = (pick > 96) ? CMD_BASE_END : CMD_BASE_BYTE;
                    PH_LIT:  if (pick > 96) cmd = CMD_DELTA_END;
                    PH_TAIL: cmd = (pick > 86) ? CMD_BASE_END : CMD_BASE_BYTE;
                    default: cmd = CMD_START;
                endcase
            end
            was_done = (dec_phase == PH_DONE);
            send_item(cmd, dbyte, r);
            if (!r.protocol_error && (!was_done || cmd == CMD_START))
                counted++;
            if ($urandom_range(0, 199) == 0)
                wait_all_results();
        end
        quiet = 1'b0;
    endtask

    initial begin
        limit_reg = LIMIT_RST;
        clear_stream();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stream_rules();
        test_output_limit();
        run_random(180, 16'hFFFF, 1'b0);
        run_random(100, 16'($urandom_range(4, 60)), 1'b0);
        run_random(90, 16'hFFFF, 1'b1);
        run_random(10, 16'($urandom_range(0, 3)), 1'b0);
        run_random(100, 16'($urandom_range(4, 400)), 1'b0);
        wait_all_results();
        repeat (8) @(posedge i_clk);

        if (decoded_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, decoded_q.size());
            err_cnt++;
        end
        $display("sent %0d items, checked %0d results, %0d rebuilt bytes, %0d limit writes",
                 tx_cnt, rx_cnt, byte_hits, limit_writes);
        $display("streams with copy and literal runs, misplaced items, restarts and limits");
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
